// File: rtl/lzw12_pkg.sv
// ----------------------------------------------------------------------------
// lzw12_pkg
// Types, state encoding and constants shared by the 12-bit LZW compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw12_pkg;

  localparam int CODE_W = 12;
  localparam int BYTE_W = 8;
  localparam int FIRST_FREE_CODE = 256;
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_input;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last_code;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_MOD,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_EMIT_PREV,
    ST_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic accept;
    logic first;
    logic mix;
    logic mod_step;
    logic probe_cmp;
    logic emit_prev;
    logic emit_last;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic prefix_valid;
    logic end_flag;
    logic mod_last;
    logic hit;
    logic used;
    logic probes_last;
    logic out_free;
    logic epoch_wrap;
    logic clear_last;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/lzw12_ram.sv
// ----------------------------------------------------------------------------
// lzw12_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/lzw12_ctrl.sv
// ----------------------------------------------------------------------------
// lzw12_ctrl
// Sequencer for the compressor: input handshake, hashing, probing and output.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw12_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire lzw12_pkg::status_t  status,
  output      lzw12_pkg::cmd_t     cmd
);

  lzw12_pkg::state_t state_r;
  lzw12_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzw12_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      lzw12_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = lzw12_pkg::ST_IDLE;
        end
      end
      lzw12_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.prefix_valid) begin
            cmd.first = 1'b1;
            state_nxt = status.end_flag ? lzw12_pkg::ST_EMIT_LAST : lzw12_pkg::ST_IDLE;
          end else begin
            state_nxt = lzw12_pkg::ST_MIX;
          end
        end
      end
      lzw12_pkg::ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = lzw12_pkg::ST_MOD;
      end
      lzw12_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_nxt = lzw12_pkg::ST_PROBE_RD;
        end
      end
      lzw12_pkg::ST_PROBE_RD: begin
        state_nxt = lzw12_pkg::ST_PROBE_CMP;
      end
      lzw12_pkg::ST_PROBE_CMP: begin
        cmd.probe_cmp = 1'b1;
        if (status.hit) begin
          state_nxt = status.end_flag ? lzw12_pkg::ST_EMIT_LAST : lzw12_pkg::ST_IDLE;
        end else if (!status.used || status.probes_last) begin
          state_nxt = lzw12_pkg::ST_EMIT_PREV;
        end
      end
      lzw12_pkg::ST_EMIT_PREV: begin
        if (status.out_free) begin
          cmd.emit_prev = 1'b1;
          state_nxt = status.end_flag ? lzw12_pkg::ST_EMIT_LAST : lzw12_pkg::ST_IDLE;
        end
      end
      lzw12_pkg::ST_EMIT_LAST: begin
        if (status.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt = status.epoch_wrap ? lzw12_pkg::ST_CLEAR : lzw12_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzw12_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lzw12_dp.sv
// ----------------------------------------------------------------------------
// lzw12_dp
// Datapath: prefix and code registers, hash unit, dictionary table, output.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw12_dp #(
  parameter int DICT_ENTRIES = 4096,
  parameter int HASH_SLOTS   = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lzw12_pkg::in_t      in_data,
  input  wire lzw12_pkg::cmd_t     cmd,
  output      lzw12_pkg::status_t  status,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      lzw12_pkg::out_t     out_data
);

  localparam int CW   = $clog2(DICT_ENTRIES);
  localparam int NCW  = $clog2(DICT_ENTRIES + 1);
  localparam int SB   = $clog2(HASH_SLOTS);
  localparam int KW   = CW + lzw12_pkg::BYTE_W;
  localparam int EW   = lzw12_pkg::EPOCH_W;
  localparam int WW   = EW + KW + CW;
  localparam int KMAX = 32 - SB;
  localparam int MCW  = $clog2(KMAX + 1);
  localparam int OW   = (CW > lzw12_pkg::CODE_W) ? CW : lzw12_pkg::CODE_W;
  localparam bit POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
  localparam logic [63:0] DIV_FULL = 64'(HASH_SLOTS) << KMAX;
  localparam logic [31:0] DIV_INIT = DIV_FULL[31:0];

  logic [CW-1:0]                 prefix_r, prefix_nxt;
  logic                          prefix_valid_r, prefix_valid_nxt;
  logic [NCW-1:0]                next_code_r, next_code_nxt;
  logic [EW-1:0]                 epoch_r, epoch_nxt;
  logic [lzw12_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic                          end_r, end_nxt;
  logic [KW-1:0]                 key_r, key_nxt;
  logic [31:0]                   mul_r, mul_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [31:0]                   div_r, div_nxt;
  logic [MCW-1:0]                mcnt_r, mcnt_nxt;
  logic [SB-1:0]                 idx_r, idx_nxt;
  logic [SB-1:0]                 pcnt_r, pcnt_nxt;
  logic                          free_r, free_nxt;
  logic [SB-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lzw12_pkg::out_t               out_r, out_nxt;

  logic [KW-1:0]  key_in;
  logic [31:0]    mix;
  logic [31:0]    rem_step;
  logic [SB-1:0]  idx_inc;
  logic [OW-1:0]  prefix_ext;
  logic           ram_we;
  logic [SB-1:0]  ram_waddr;
  logic [WW-1:0]  ram_wdata;
  logic [SB-1:0]  ram_raddr;
  logic [WW-1:0]  ram_rdata;
  logic [EW-1:0]  rd_epoch;
  logic [KW-1:0]  rd_key;
  logic [CW-1:0]  rd_code;
  logic           used, hit, probes_last, mod_last, out_free, can_insert;

  lzw12_ram #(
    .WIDTH (WW),
    .DEPTH (HASH_SLOTS)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_in      = {prefix_r, in_data.data_byte};
  assign mix         = mul_r ^ (mul_r >> 15);
  assign rem_step    = (rem_r >= div_r) ? (rem_r - div_r) : rem_r;
  assign mod_last    = POW2 || (mcnt_r == '0);
  assign idx_inc     = (idx_r == SB'(HASH_SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign prefix_ext  = OW'(prefix_r);
  assign rd_epoch    = ram_rdata[WW-1 -: EW];
  assign rd_key      = ram_rdata[CW +: KW];
  assign rd_code     = ram_rdata[CW-1:0];
  assign used        = rd_epoch == epoch_r;
  assign hit         = used && (rd_key == key_r);
  assign probes_last = pcnt_r == SB'(HASH_SLOTS - 1);
  assign out_free    = !out_valid_r || !out_stall;
  assign can_insert  = free_r && (next_code_r < NCW'(DICT_ENTRIES));
  assign ram_raddr   = cmd.probe_cmp ? idx_inc : idx_r;

  assign status.prefix_valid = prefix_valid_r;
  assign status.end_flag     = cmd.accept ? in_data.end_of_input : end_r;
  assign status.mod_last     = mod_last;
  assign status.hit          = hit;
  assign status.used         = used;
  assign status.probes_last  = probes_last;
  assign status.out_free     = out_free;
  assign status.epoch_wrap   = epoch_r == '1;
  assign status.clear_last   = clr_cnt_r == SB'(HASH_SLOTS - 1);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    prefix_nxt       = prefix_r;
    prefix_valid_nxt = prefix_valid_r;
    next_code_nxt    = next_code_r;
    epoch_nxt        = epoch_r;
    byte_nxt         = byte_r;
    end_nxt          = end_r;
    key_nxt          = key_r;
    mul_nxt          = mul_r;
    rem_nxt          = rem_r;
    div_nxt          = div_r;
    mcnt_nxt         = mcnt_r;
    idx_nxt          = idx_r;
    pcnt_nxt         = pcnt_r;
    free_nxt         = free_r;
    clr_cnt_nxt      = clr_cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_nxt          = out_r;
    ram_we           = 1'b0;
    ram_waddr        = idx_r;
    ram_wdata        = {epoch_r, key_r, next_code_r[CW-1:0]};

    if (cmd.accept) begin
      byte_nxt = in_data.data_byte;
      end_nxt  = in_data.end_of_input;
      key_nxt  = key_in;
      mul_nxt  = 32'(key_in) * lzw12_pkg::HASH_MULT;
    end
    if (cmd.first) begin
      prefix_nxt       = CW'(in_data.data_byte);
      prefix_valid_nxt = 1'b1;
    end
    if (cmd.mix) begin
      rem_nxt  = mix;
      div_nxt  = DIV_INIT;
      mcnt_nxt = MCW'(KMAX);
    end
    if (cmd.mod_step) begin
      rem_nxt  = rem_step;
      div_nxt  = div_r >> 1;
      mcnt_nxt = mcnt_r - 1'b1;
      if (mod_last) begin
        idx_nxt  = POW2 ? rem_r[SB-1:0] : rem_step[SB-1:0];
        pcnt_nxt = '0;
      end
    end
    if (cmd.probe_cmp) begin
      if (hit) begin
        prefix_nxt = rd_code;
      end else if (!used) begin
        free_nxt = 1'b1;
      end else if (probes_last) begin
        free_nxt = 1'b0;
      end else begin
        idx_nxt  = idx_inc;
        pcnt_nxt = pcnt_r + 1'b1;
      end
    end
    if (cmd.emit_prev) begin
      out_valid_nxt = 1'b1;
      out_nxt.code      = prefix_ext[lzw12_pkg::CODE_W-1:0];
      out_nxt.last_code = 1'b0;
      if (can_insert) begin
        ram_we        = 1'b1;
        next_code_nxt = next_code_r + 1'b1;
      end
      prefix_nxt = CW'(byte_r);
    end
    if (cmd.emit_last) begin
      out_valid_nxt = 1'b1;
      out_nxt.code      = prefix_ext[lzw12_pkg::CODE_W-1:0];
      out_nxt.last_code = 1'b1;
      prefix_nxt        = '0;
      prefix_valid_nxt  = 1'b0;
      next_code_nxt     = NCW'(lzw12_pkg::FIRST_FREE_CODE);
      epoch_nxt         = epoch_r + 1'b1;
    end
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
      if (clr_cnt_r == SB'(HASH_SLOTS - 1)) begin
        clr_cnt_nxt = '0;
        epoch_nxt   = lzw12_pkg::EPOCH_ONE;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r       <= '0;
      prefix_valid_r <= 1'b0;
      next_code_r    <= NCW'(lzw12_pkg::FIRST_FREE_CODE);
      epoch_r        <= '0;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      end_r          <= 1'b0;
      free_r         <= 1'b0;
    end else begin
      prefix_r       <= prefix_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      next_code_r    <= next_code_nxt;
      epoch_r        <= epoch_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      end_r          <= end_nxt;
      free_r         <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    key_r  <= key_nxt;
    mul_r  <= mul_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    mcnt_r <= mcnt_nxt;
    idx_r  <= idx_nxt;
    pcnt_r <= pcnt_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/lzw_compress_12bit_core.sv
// ----------------------------------------------------------------------------
// lzw_compress_12bit_core
// Streaming LZW compressor: one byte per request in, 12-bit codes out.
// ----------------------------------------------------------------------------
// Each request carries one byte; a byte that extends the current string is
// absorbed, otherwise the string's code is sent and, while a free slot and a
// spare code remain, a new dictionary entry is made. The final byte flushes
// the pending code, marked as last, and the next stream starts with an empty
// dictionary. The first byte of a stream only starts the string, and is sent
// at once when it is also the final byte. Any other byte is hashed, reduced
// to a slot and probed along successive slots until a hit, an unused slot or
// every slot probed; the table is a single memory with one registered read port.
// When HASH_SLOTS is not a power of two the slot reduction is done by repeated
// conditional subtraction. After reset, and after every fifteenth stream, the
// table is swept slot by slot and no request is taken during the sweep.
`default_nettype none

module lzw_compress_12bit_core #(
  parameter int DICT_ENTRIES = 4096,
  parameter int HASH_SLOTS   = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire lzw12_pkg::in_t   in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      lzw12_pkg::out_t  out_data
);

  lzw12_pkg::cmd_t    cmd;
  lzw12_pkg::status_t status;

  lzw12_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lzw12_dp #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .HASH_SLOTS   (HASH_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
